>>> src/q15_fir_filter_assert.svh
`ifndef Q15_FIR_FILTER_ASSERT_SVH
`define Q15_FIR_FILTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define Q15FIR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition leads to another one on the next clock edge.
`define Q15FIR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/q15fir_pkg.sv
`default_nettype none

package q15fir_pkg;

    localparam logic [1:0] FUNC_WCOEF  = 2'd0;
    localparam logic [1:0] FUNC_FILTER = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef logic [2:0] step_t;

    localparam step_t STEP_FETCH = 3'd0;
    localparam step_t STEP_WCOEF = 3'd1;
    localparam step_t STEP_CLEAR = 3'd2;
    localparam step_t STEP_MAC   = 3'd3;
    localparam step_t STEP_DRAIN = 3'd4;
    localparam step_t STEP_SAT   = 3'd5;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_DISPATCH,
        BR_LOOP,
        BR_OUTWAIT
    } br_t;

    typedef struct packed {
        logic  in_ready;
        logic  coef_we;
        logic  clr_hist;
        logic  mac;
        logic  sat_load;
        br_t   br;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic loop_more;
        logic out_free;
    } status_t;

    function automatic ctrl_t microcode(input step_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, coef_we: 1'b0, clr_hist: 1'b0, mac: 1'b0,
              sat_load: 1'b0, br: BR_GOTO, target: STEP_FETCH};
        case (step)
            STEP_FETCH:
            begin
                w.in_ready = 1'b1;
                w.br       = BR_DISPATCH;
            end
            STEP_WCOEF:
            begin
                w.coef_we = 1'b1;
            end
            STEP_CLEAR:
            begin
                w.clr_hist = 1'b1;
            end
            STEP_MAC:
            begin
                w.mac    = 1'b1;
                w.br     = BR_LOOP;
                w.target = STEP_MAC;
            end
            STEP_DRAIN:
            begin
                w.br = BR_NEXT;
            end
            STEP_SAT:
            begin
                w.sat_load = 1'b1;
                w.br       = BR_OUTWAIT;
            end
            default:
            begin
                w.br = BR_GOTO;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/q15_fir_filter.sv
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tuser: func; tdata: coef_index, value
// m_axis    out  tvalid/tready         tdata: filtered; tuser: saturated
// cfg       in   cfg_we                cfg_data: taps_in_use
//
// A sample word runs one multiply-accumulate per tap in use, one per cycle
// on the single multiplier, fed by the registered reads of the coefficient
// and history RAMs.
// Coefficient write and history clear run their own step; unused funcs return to fetch.
// Reset clears the history valid bits and sets taps_in_use to TAPS (at most 63);
// coefficients hold nothing until written.
// A result waits in the output register while the next word is taken; with
// the output still full, the sequencer holds at its final step.
`default_nettype none

module q15_fir_filter #(
    parameter int TAPS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [4:0] coef_index, [20:5] value, [23:21] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] filtered
    output logic             m_axis_tuser,   // [0] saturated
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_data
);

    import q15fir_pkg::*;

    localparam int TAPS_RST = (TAPS > 63) ? 63 : TAPS;

    ctrl_t              ctrl;
    status_t            status;
    logic               accept;
    logic [5:0]         taps_reg;
    logic signed [15:0] filtered;

    assign s_axis_tready = ctrl.in_ready;
    assign accept        = s_axis_tvalid && ctrl.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= 6'(TAPS_RST);
        end
        else if (cfg_we)
        begin
            taps_reg <= cfg_data;
        end
    end

    q15fir_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .func  (s_axis_tuser),
        .status(status),
        .ctrl  (ctrl)
    );

    q15fir_dp #(
        .TAPS(TAPS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .accept     (accept),
        .coef_index (s_axis_tdata[4:0]),
        .value      (s_axis_tdata[20:5]),
        .taps_in_use(taps_reg),
        .out_ready  (m_axis_tready),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .filtered   (filtered),
        .saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = filtered;

endmodule

`default_nettype wire

>>> src/q15fir_ram.sv
`default_nettype none

module q15fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/q15fir_seq.sv
`default_nettype none

`include "q15_fir_filter_assert.svh"

module q15fir_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [1:0]          func,
    input  wire q15fir_pkg::status_t status,
    output q15fir_pkg::ctrl_t        ctrl
);

    import q15fir_pkg::*;

    step_t step_reg;
    step_t step_next;

    assign ctrl = microcode(step_reg);

    always_comb
    begin
        step_next = step_reg;
        case (ctrl.br)
            BR_NEXT:
            begin
                step_next = step_reg + 3'd1;
            end
            BR_GOTO:
            begin
                step_next = ctrl.target;
            end
            BR_DISPATCH:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_WCOEF:  step_next = STEP_WCOEF;
                        FUNC_FILTER: step_next = STEP_MAC;
                        FUNC_CLEAR:  step_next = STEP_CLEAR;
                        default:     step_next = STEP_FETCH;
                    endcase
                end
            end
            BR_LOOP:
            begin
                step_next = status.loop_more ? ctrl.target : step_reg + 3'd1;
            end
            BR_OUTWAIT:
            begin
                step_next = status.out_free ? ctrl.target : step_reg;
            end
            default:
            begin
                step_next = STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `Q15FIR_ASSERT_NEXT(a_filter_enters_mac, accept && (func == FUNC_FILTER), step_reg == STEP_MAC, "filter word did not start tap loop")
    `Q15FIR_ASSERT_NEXT(a_loop_exits_to_drain, (step_reg == STEP_MAC) && !status.loop_more, step_reg == STEP_DRAIN, "tap loop did not drain")
    `Q15FIR_ASSERT_NEXT(a_sat_holds, (step_reg == STEP_SAT) && !status.out_free, step_reg == STEP_SAT, "result step left while output busy")
    `Q15FIR_ASSERT_CLK(a_wcoef_from_fetch, (step_reg == STEP_WCOEF) |-> ($past(step_reg) == STEP_FETCH), "coefficient write not dispatched")

endmodule

`default_nettype wire

>>> src/q15fir_dp.sv
`default_nettype none

module q15fir_dp #(
    parameter int TAPS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire q15fir_pkg::ctrl_t   ctrl,
    input  wire logic                accept,
    input  wire logic [4:0]          coef_index,
    input  wire logic signed [15:0]  value,
    input  wire logic [5:0]          taps_in_use,
    input  wire logic                out_ready,
    output q15fir_pkg::status_t      status,
    output logic                     out_valid,
    output logic signed [15:0]       filtered,
    output logic                     saturated
);

    import q15fir_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int KW    = $clog2(TAPS + 1);
    localparam int ACC_W = 32 + $clog2(TAPS);
    localparam int QS    = 15;
    localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] RES_MIN = ACC_W'(-32768);

    logic [4:0]               idx_reg;
    logic signed [15:0]       val_reg;
    logic [KW-1:0]            k_reg;
    logic [AW-1:0]            wk_reg;
    logic                     tv_reg;
    logic                     rdv_reg;
    logic                     pv_reg;
    logic signed [15:0]       carry_reg;
    logic signed [31:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [TAPS-1:0]          hv_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       filtered_reg;
    logic                     saturated_reg;

    logic [KW-1:0]            n_taps;
    logic [AW-1:0]            raddr;
    logic                     coef_we;
    logic [15:0]              coef_rd;
    logic [15:0]              hist_rd;
    logic signed [31:0]       prod_next;
    logic signed [ACC_W-1:0]  sh;
    logic                     sat_hi;
    logic                     sat_lo;
    logic                     out_free;
    logic                     load_out;

    assign n_taps   = (32'(taps_in_use) > TAPS) ? KW'(TAPS) : KW'(taps_in_use);
    assign raddr    = k_reg[AW-1:0];
    assign coef_we  = ctrl.coef_we && (32'(idx_reg) < TAPS);
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = ctrl.sat_load && out_free;

    assign status.loop_more = (k_reg < n_taps);
    assign status.out_free  = out_free;

    q15fir_ram #(
        .WIDTH(16),
        .DEPTH(TAPS)
    ) u_coef_ram (
        .clk  (clk),
        .we   (coef_we),
        .waddr(AW'(idx_reg)),
        .wdata(val_reg),
        .raddr(raddr),
        .rdata(coef_rd)
    );

    q15fir_ram #(
        .WIDTH(16),
        .DEPTH(TAPS)
    ) u_hist_ram (
        .clk  (clk),
        .we   (tv_reg),
        .waddr(wk_reg),
        .wdata(carry_reg),
        .raddr(raddr),
        .rdata(hist_rd)
    );

    assign prod_next = $signed(coef_rd) * carry_reg;
    assign sh        = acc_reg >>> QS;
    assign sat_hi    = (sh > RES_MAX);
    assign sat_lo    = (sh < RES_MIN);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= coef_index;
            val_reg <= value;
        end
        if (ctrl.mac)
        begin
            wk_reg <= raddr;
        end
        if (accept)
        begin
            carry_reg <= value;
        end
        else if (tv_reg)
        begin
            carry_reg <= rdv_reg ? hist_rd : 16'sd0;
            prod_reg  <= prod_next;
        end
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (load_out)
        begin
            filtered_reg  <= sat_hi ? 16'sh7FFF : (sat_lo ? 16'sh8000 : sh[15:0]);
            saturated_reg <= sat_hi || sat_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            tv_reg        <= 1'b0;
            rdv_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            hv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                k_reg <= '0;
            end
            else if (ctrl.mac)
            begin
                k_reg <= k_reg + KW'(1);
            end
            tv_reg  <= ctrl.mac && (k_reg < n_taps);
            rdv_reg <= hv_reg[raddr];
            pv_reg  <= tv_reg && !accept;
            if (ctrl.clr_hist)
            begin
                hv_reg <= '0;
            end
            else if (tv_reg)
            begin
                hv_reg[wk_reg] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

>>> tb/sv/fir_output_checker.sv
`timescale 1ns / 100ps

module fir_output_checker
    import q15fir_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [23:0] in_data,
    input  logic [1:0]  in_func,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_data,
    input  logic        out_sat,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    output int          errors,
    output int          outstanding,
    output int          checked,
    output int          clipped
);

    localparam int Q_FRAC = 15;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               saturated;
    } fir_out_t;

    logic signed [15:0] coef_table [TAPS];
    logic signed [15:0] history [TAPS];
    logic [5:0]         taps_used;
    fir_out_t           pending_outputs [$];

    function automatic fir_out_t filter_sample(input logic signed [15:0] x);
        fir_out_t           r;
        longint             acc;
        longint             sum_q;
        logic signed [15:0] carry;
        logic signed [15:0] prev;
        int                 n;
        int                 i;
        n = (taps_used > TAPS) ? TAPS : int'(taps_used);
        acc = 0;
        carry = x;
        for (i = 0; i < n; i++)
        begin
            acc += longint'(coef_table[i]) * longint'(carry);
            prev = history[i];
            history[i] = carry;
            carry = prev;
        end
        sum_q = acc >>> Q_FRAC;
        r.saturated = 1'b1;
        if (sum_q > 32767)
            r.filtered = 16'sh7FFF;
        else if (sum_q < -32768)
            r.filtered = 16'sh8000;
        else
        begin
            r.filtered = 16'(sum_q);
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        fir_out_t           want;
        logic [4:0]         idx;
        logic signed [15:0] val;
        int                 k;
        if (!rst_n)
        begin
            for (k = 0; k < TAPS; k++)
                history[k] = '0;
            taps_used = 6'(TAPS);
            pending_outputs.delete();
            errors = 0;
            checked = 0;
            clipped = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output word, filtered %0d saturated %0b",
                             $time, $signed(out_data), out_sat);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    checked++;
                    if (want.saturated)
                        clipped++;
                    if (want.filtered !== out_data)
                    begin
                        errors++;
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, $signed(want.filtered), $signed(out_data));
                    end
                    if (want.saturated !== out_sat)
                    begin
                        errors++;
                        $display("%0t: saturated mismatch, expected %0b, got %0b",
                                 $time, want.saturated, out_sat);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                idx = in_data[4:0];
                val = in_data[20:5];
                case (in_func)
                    FUNC_WCOEF:  coef_table[idx] = val;
                    FUNC_FILTER: pending_outputs.push_back(filter_sample(val));
                    FUNC_CLEAR:
                        for (k = 0; k < TAPS; k++)
                            history[k] = '0;
                    default: ;
                endcase
            end
            if (cfg_we)
                taps_used = cfg_data;
        end
        outstanding = pending_outputs.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import q15fir_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TAPS            = 32;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_GAP        = 8;
    localparam int WORDS_PER_PHASE = 116;
    localparam int PHASES          = 9;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_data = '0;

    int errors;
    int outstanding;
    int checked;
    int clipped;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int words_sent = 0;
    int tap_settings = 0;

    logic [5:0] phase_taps [PHASES] = '{6'd32, 6'd7, 6'd63, 6'd1, 6'd16,
                                        6'd32, 6'd25, 6'd2, 6'd31};

    q15_fir_filter #(
        .TAPS (TAPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    fir_output_checker #(
        .TAPS (TAPS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_func     (s_axis_tuser),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_sat     (m_axis_tuser),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .clipped     (clipped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold off the output for a long stretch on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("q15_fir_filter test failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] func, input logic [4:0] idx,
                             input logic [15:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {3'b000, value, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (func != FUNC_UNUSED)
            words_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    task automatic write_taps(input logic [5:0] taps);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= taps;
        @(negedge clk);
        cfg_we <= 1'b0;
        tap_settings++;
    endtask

    function automatic logic [15:0] pick_sample();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_coef();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(2047)) - 16'd1024;
    endfunction

    initial
    begin : stimulus
        int p;
        int n;
        int r;
        int k;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_taps(6'd4);
        send_word(FUNC_WCOEF, 5'd0, 16'h7FFF);
        send_word(FUNC_WCOEF, 5'd1, 16'h8000);
        send_word(FUNC_WCOEF, 5'd2, 16'h4000);
        send_word(FUNC_WCOEF, 5'd3, 16'hFFFF);
        send_word(FUNC_WCOEF, 5'd31, 16'h8000);
        send_word(FUNC_FILTER, 5'd0, 16'h7FFF);
        send_word(FUNC_FILTER, 5'd31, 16'h8000);
        send_word(FUNC_FILTER, 5'd0, 16'h8000);
        send_word(FUNC_FILTER, 5'd0, 16'h0000);
        send_word(FUNC_FILTER, 5'd0, 16'h0001);
        send_word(FUNC_FILTER, 5'd0, 16'hFFFF);
        send_word(FUNC_UNUSED, 5'd31, 16'hFFFF);
        send_word(FUNC_CLEAR, 5'd0, 16'h0000);
        send_word(FUNC_FILTER, 5'd0, 16'd12345);
        write_taps(6'd1);
        send_word(FUNC_FILTER, 5'd0, 16'h8000);
        send_word(FUNC_FILTER, 5'd0, 16'h7FFF);
        write_taps(6'd0);
        send_word(FUNC_FILTER, 5'd0, 16'h7FFF);
        write_taps(6'd4);
        send_word(FUNC_FILTER, 5'd0, 16'd100);

        // fill the whole coefficient table before any wider filtering
        for (k = 0; k < TAPS; k++)
            send_word(FUNC_WCOEF, 5'(k), pick_coef());

        for (p = 0; p < PHASES; p++)
        begin
            write_taps(phase_taps[p]);
            src_idle_pct = (p < 3) ? 13 : (p < 6) ? 53 : 0;
            sink_idle_pct <= (p < 3) ? 53 : (p < 6) ? 13 : 0;
            if (p == 1)
                hold_reqs <= hold_reqs + 1;
            n = 0;
            while (n < WORDS_PER_PHASE)
            begin
                r = $urandom_range(99);
                if (r < 78)
                begin
                    send_word(FUNC_FILTER, 5'($urandom), pick_sample());
                    n++;
                end
                else if (r < 90)
                begin
                    send_word(FUNC_WCOEF, 5'($urandom), pick_coef());
                    n++;
                end
                else if (r < 95)
                begin
                    send_word(FUNC_CLEAR, 5'($urandom), 16'($urandom));
                    n++;
                end
                else
                    send_word(FUNC_UNUSED, 5'($urandom), 16'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d words over %0d tap settings; %0d filter outputs checked, %0d clipped.",
                 words_sent, tap_settings, checked, clipped);
        if (errors == 0)
            $display("q15_fir_filter test passed");
        else
            $display("q15_fir_filter test failed");
        $finish;
    end

endmodule

>>> q15_fir_filter.f
+incdir+src
src/q15fir_pkg.sv
src/q15fir_ram.sv
src/q15fir_seq.sv
src/q15fir_dp.sv
src/q15_fir_filter.sv
tb/sv/fir_output_checker.sv
tb/sv/tb_top.sv
